// File: src/lcdpr_pkg.sv
// Shared types and constants of the LCD cell pixel renderer.
// No dependencies; lcdpr_render, lcd_cell_pixel_renderer and lcdpr_checker import this package.
package lcdpr_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT40 = 2'd0,
    MODE_TEXT80 = 2'd1,
    MODE_GFX320 = 2'd2,
    MODE_GFX640 = 2'd3
  } lcdpr_mode_t;

  typedef enum logic [2:0] {
    REG_ATTR_MAP     = 3'd0,
    REG_DISPLAY_MODE = 3'd1,
    REG_BLINK_ENABLE = 3'd2,
    REG_VIDEO_ENABLE = 3'd3,
    REG_CURSOR_START = 3'd4,
    REG_CURSOR_END   = 3'd5,
    REG_CURSOR_OFF   = 3'd6,
    REG_INK_SELECT   = 3'd7
  } lcdpr_reg_t;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [4:0] COUNT_NARROW = 5'd8;
  localparam logic [4:0] COUNT_WIDE   = 5'd16;

  localparam logic [3:0]  RST_ATTR_MAP     = 4'd0;
  localparam lcdpr_mode_t RST_DISPLAY_MODE = MODE_TEXT80;
  localparam logic        RST_BLINK_ENABLE = 1'b0;
  localparam logic        RST_VIDEO_ENABLE = 1'b1;
  localparam logic [3:0]  RST_CURSOR_START = 4'd6;
  localparam logic [3:0]  RST_CURSOR_END   = 4'd7;
  localparam logic        RST_CURSOR_OFF   = 1'b0;
  localparam logic        RST_INK_SELECT   = 1'b1;

  typedef struct packed {
    logic [3:0]  attr_map;
    lcdpr_mode_t display_mode;
    logic        blink_enable;
    logic        video_enable;
    logic [3:0]  cursor_start;
    logic [3:0]  cursor_end;
    logic        cursor_off;
    logic        ink_select;
  } lcdpr_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] attr_byte;
    logic [7:0] font_row_plain;
    logic [7:0] font_row_bold;
    logic [7:0] scanline;
    logic       at_cursor;
    logic       blink_phase;
  } lcdpr_item_t;

  typedef struct packed {
    logic [15:0] pixel_mask;
    logic [4:0]  pixel_count;
  } lcdpr_res_t;

endpackage

// File: src/lcdpr_if.sv
// Valid/ready channels of the LCD cell pixel renderer: input item and result item.
// No dependencies.
interface lcdpr_in_if ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] attr_byte;
  logic [7:0] font_row_plain;
  logic [7:0] font_row_bold;
  logic [7:0] scanline;
  logic       at_cursor;
  logic       blink_phase;

  modport source (
    output valid, data_byte, attr_byte, font_row_plain, font_row_bold, scanline,
           at_cursor, blink_phase,
    input  ready
  );
  modport sink (
    input  valid, data_byte, attr_byte, font_row_plain, font_row_bold, scanline,
           at_cursor, blink_phase,
    output ready
  );
endinterface

interface lcdpr_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] pixel_mask;
  logic [4:0]  pixel_count;

  modport source (output valid, pixel_mask, pixel_count, input ready);
  modport sink (input valid, pixel_mask, pixel_count, output ready);
endinterface

// File: src/lcdpr_render.sv
// Combinational pixel row generation for one registered item.
// Depends on lcdpr_pkg.
module lcdpr_render import lcdpr_pkg::*; (
  input  lcdpr_cfg_t  cfg,
  input  lcdpr_item_t item,
  output lcdpr_res_t  res
);

  // bit 0: clear font bits draw foreground; bit 1: set font bits draw foreground
  function automatic logic [1:0] attr_levels(input logic [7:0] n, input logic btab,
                                             input logic [3:0] amap);
    logic [7:0] r;
    logic [1:0] lv;
    r = btab ? {1'b0, n[6:0]} : n;
    if (btab && ({1'b0, r[6:4]} == r[3:0])) lv = 2'd0;
    else if (!btab && (n[7:4] == n[3:0])) lv = 2'd0;
    else if (n == 8'h07 || n == 8'h0F) lv = 2'd2;
    else if (btab && (n == 8'h87 || n == 8'h8F)) lv = 2'd2;
    else if (!btab && n >= 8'h81 && n <= 8'h8F) lv = 2'd2;
    else if (r >= 8'h01 && r <= 8'h0E && r != 8'h07) lv = amap[0] ? 2'd1 : 2'd2;
    else if (n >= 8'h11 && n[2:0] != 3'd0) lv = amap[2] ? 2'd1 : 2'd2;
    else lv = 2'd1;
    return lv;
  endfunction

  function automatic logic attr_bold(input logic [7:0] n, input logic [3:0] amap);
    logic b;
    if (n >= 8'h81 && n <= 8'h8F) b = n[3];
    else if (n >= 8'h01 && n <= 8'h0E && n != 8'h07 && amap[1]) b = 1'b1;
    else if (n >= 8'h11 && n[2:0] != 3'd0 && amap[3]) b = 1'b1;
    else b = n[3];
    return b;
  endfunction

  logic [2:0]  cell_row;
  logic        cur_line;
  logic        cursor;
  logic        blink;
  logic [1:0]  lv_base;
  logic [1:0]  lv;
  logic [7:0]  font;
  logic [7:0]  m0;
  logic [7:0]  m1;
  logic [7:0]  row;
  logic [15:0] text_mask;
  logic [7:0]  gfx_mask;
  logic [1:0]  pat;

  always_comb begin
    cell_row = item.scanline[2:0];
    cur_line = !cfg.cursor_off && (cfg.cursor_start <= {1'b0, cell_row})
               && (cfg.cursor_end >= {1'b0, cell_row});
    cursor   = item.at_cursor && cur_line && cfg.video_enable && item.blink_phase;
    blink    = item.blink_phase && cfg.blink_enable && item.attr_byte[7] && !cursor;
    lv_base  = attr_levels(item.attr_byte, cfg.blink_enable, cfg.attr_map);
    lv       = blink ? {2{lv_base[0]}} : lv_base;
    font     = attr_bold(item.attr_byte, cfg.attr_map) ? item.font_row_bold
                                                       : item.font_row_plain;
    m0       = {8{lv[0]}};
    m1       = {8{lv[1]}};
    row      = ((font & m1) | (~font & m0)) ^ {8{cursor}};
    for (int k = 0; k < 8; k++) begin
      text_mask[2*k +: 2] = {2{row[k]}};
    end

    // dither each 2-bit color into a pixel pair by line parity
    for (int i = 0; i < 4; i++) begin
      pat = cfg.video_enable ? item.data_byte[2*i +: 2] : 2'd0;
      if (pat == 2'd0) gfx_mask[2*i +: 2] = 2'b00;
      else if (pat == 2'd3) gfx_mask[2*i +: 2] = 2'b11;
      else if (!item.scanline[0]) gfx_mask[2*i +: 2] = 2'b10;
      else gfx_mask[2*i +: 2] = (pat == 2'd2) ? 2'b01 : 2'b00;
    end

    res.pixel_count = COUNT_NARROW;
    unique case (cfg.display_mode)
      MODE_GFX640: begin
        res.pixel_mask = {8'h00, (cfg.video_enable && cfg.ink_select) ? item.data_byte
                                                                      : 8'h00};
      end
      MODE_GFX320: begin
        res.pixel_mask = {8'h00, gfx_mask};
      end
      MODE_TEXT40: begin
        res.pixel_mask  = text_mask;
        res.pixel_count = COUNT_WIDE;
      end
      MODE_TEXT80: begin
        res.pixel_mask = {8'h00, row};
      end
    endcase
  end

endmodule

// File: src/lcd_cell_pixel_renderer.sv
// Top level of the LCD cell pixel renderer: register file, input and result stages.
// Depends on lcdpr_pkg, lcdpr_if and lcdpr_render.
//
// Takes one fetched display byte with its attribute, font rows and line context per
// item and returns one foreground pixel mask per item (8 pixels, or 16 in 40-column
// text). One item is accepted every clock cycle while the output is not stalled; each
// result passes through the input register and then the result register around the single
// rendering stage. Both stages hold under back-pressure, so in_ch.ready follows
// out_ch.ready combinationally. The user must write registers through the APB port
// only while no item is in flight; the block itself does not enforce this.
module lcd_cell_pixel_renderer import lcdpr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lcdpr_in_if.sink              in_ch,
  lcdpr_out_if.source           out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  lcdpr_cfg_t  cfg_r;
  lcdpr_reg_t  reg_sel;
  logic        cfg_wr;
  lcdpr_item_t in_item;
  lcdpr_item_t s1_item_r;
  logic        s1_v_r;
  lcdpr_res_t  res_nxt;
  lcdpr_res_t  s2_res_r;
  logic        s2_v_r;
  logic        s1_adv;
  logic        s2_adv;

  assign cfg_pready = 1'b1;
  assign reg_sel    = lcdpr_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attr_map     <= RST_ATTR_MAP;
      cfg_r.display_mode <= RST_DISPLAY_MODE;
      cfg_r.blink_enable <= RST_BLINK_ENABLE;
      cfg_r.video_enable <= RST_VIDEO_ENABLE;
      cfg_r.cursor_start <= RST_CURSOR_START;
      cfg_r.cursor_end   <= RST_CURSOR_END;
      cfg_r.cursor_off   <= RST_CURSOR_OFF;
      cfg_r.ink_select   <= RST_INK_SELECT;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ATTR_MAP:     cfg_r.attr_map     <= cfg_pwdata[3:0];
        REG_DISPLAY_MODE: cfg_r.display_mode <= lcdpr_mode_t'(cfg_pwdata[1:0]);
        REG_BLINK_ENABLE: cfg_r.blink_enable <= cfg_pwdata[0];
        REG_VIDEO_ENABLE: cfg_r.video_enable <= cfg_pwdata[0];
        REG_CURSOR_START: cfg_r.cursor_start <= cfg_pwdata[3:0];
        REG_CURSOR_END:   cfg_r.cursor_end   <= cfg_pwdata[3:0];
        REG_CURSOR_OFF:   cfg_r.cursor_off   <= cfg_pwdata[0];
        REG_INK_SELECT:   cfg_r.ink_select   <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_sel)
      REG_ATTR_MAP:     cfg_prdata[3:0] = cfg_r.attr_map;
      REG_DISPLAY_MODE: cfg_prdata[1:0] = cfg_r.display_mode;
      REG_BLINK_ENABLE: cfg_prdata[0]   = cfg_r.blink_enable;
      REG_VIDEO_ENABLE: cfg_prdata[0]   = cfg_r.video_enable;
      REG_CURSOR_START: cfg_prdata[3:0] = cfg_r.cursor_start;
      REG_CURSOR_END:   cfg_prdata[3:0] = cfg_r.cursor_end;
      REG_CURSOR_OFF:   cfg_prdata[0]   = cfg_r.cursor_off;
      REG_INK_SELECT:   cfg_prdata[0]   = cfg_r.ink_select;
    endcase
  end

  assign in_item.data_byte      = in_ch.data_byte;
  assign in_item.attr_byte      = in_ch.attr_byte;
  assign in_item.font_row_plain = in_ch.font_row_plain;
  assign in_item.font_row_bold  = in_ch.font_row_bold;
  assign in_item.scanline       = in_ch.scanline;
  assign in_item.at_cursor      = in_ch.at_cursor;
  assign in_item.blink_phase    = in_ch.blink_phase;

  assign s2_adv      = !s2_v_r || out_ch.ready;
  assign s1_adv      = !s1_v_r || s2_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= in_ch.valid;
      if (s2_adv) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) s1_item_r <= in_item;
    if (s2_adv && s1_v_r) s2_res_r <= res_nxt;
  end

  lcdpr_render u_render (
    .cfg  (cfg_r),
    .item (s1_item_r),
    .res  (res_nxt)
  );

  assign out_ch.valid       = s2_v_r;
  assign out_ch.pixel_mask  = s2_res_r.pixel_mask;
  assign out_ch.pixel_count = s2_res_r.pixel_count;

endmodule

// File: src/lcdpr_checker.sv
// Port-level assertions for the LCD cell pixel renderer, bound to the top level.
// Depends on lcdpr_pkg, lcdpr_if and lcd_cell_pixel_renderer.
module lcdpr_checker import lcdpr_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  lcdpr_in_if.sink    in_ch,
  lcdpr_out_if.source out_ch
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.pixel_mask)
                                      && $stable(out_ch.pixel_count))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_in_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with no result waiting");

  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pixel_count == COUNT_NARROW |-> out_ch.pixel_mask[15:8] == 8'h00)
    else $error("upper mask bits set on narrow row");

  a_wide_doubled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pixel_count == COUNT_WIDE
    |-> (out_ch.pixel_mask & 16'h5555) == ((out_ch.pixel_mask >> 1) & 16'h5555))
    else $error("wide row pixels not doubled");

endmodule

bind lcd_cell_pixel_renderer lcdpr_checker u_lcdpr_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
